// ===== rtl/serial_frame_sync_crc_receiver_defines.svh =====
// Assertion macros used by the frame receiver top level.
`ifndef SERIAL_FRAME_SYNC_CRC_RECEIVER_DEFINES_SVH
`define SERIAL_FRAME_SYNC_CRC_RECEIVER_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define SFSC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define SFSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sfsc_pkg.sv =====
// Shared types, constants and the CRC-8 byte step for the frame receiver.
package sfsc_pkg;

   localparam int unsigned BYTE_WIDTH        = 8;
   localparam int unsigned LENGTH_WIDTH      = 7;
   localparam int unsigned CSR_INDEX_WIDTH   = 2;
   localparam int unsigned CSR_DATA_WIDTH    = 8;

   localparam int unsigned MAX_FRAME_BYTES_DEFAULT = 64;
   localparam int unsigned MIN_FRAME_BYTES_DEFAULT = 4;

   // Sync and CRC bytes not counted by the length field.
   localparam int unsigned LENGTH_OVERHEAD = 2;
   // Position of the type byte within the frame.
   localparam int unsigned TYPE_BYTE_INDEX = 2;

   localparam logic [BYTE_WIDTH-1:0] SYNC_VALUE_RESET     = 8'hC8;
   localparam logic [BYTE_WIDTH-1:0] CRC_POLYNOMIAL_RESET = 8'hD5;

   typedef logic [BYTE_WIDTH-1:0]      byte_type;
   typedef logic [LENGTH_WIDTH-1:0]    length_type;
   typedef logic [CSR_DATA_WIDTH-1:0]  csr_data_type;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SYNC_VALUE     = 2'd0,
      CSR_CRC_POLYNOMIAL = 2'd1
   } csr_index_type;

   // Framing states.
   typedef enum logic [1:0] {
      ST_HUNT,
      ST_LENGTH,
      ST_BODY
   } frame_state_type;

   typedef struct packed {
      byte_type sync_value;
      byte_type crc_polynomial;
   } cfg_type;

   typedef struct packed {
      logic       crc_ok;
      byte_type   frame_type;
      length_type frame_length;
      byte_type   computed_crc;
      byte_type   received_crc;
   } result_type;

   // One byte of a CRC-8, MSB first, unrolled over the eight bit steps.
   function automatic byte_type crc8_step(byte_type crc, byte_type data, byte_type poly);
      byte_type c;
      c = crc ^ data;
      for (int i = 0; i < BYTE_WIDTH; i++) begin
         if (c[BYTE_WIDTH-1]) begin
            c = {c[BYTE_WIDTH-2:0], 1'b0} ^ poly;
         end else begin
            c = {c[BYTE_WIDTH-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/sfsc_channels.sv =====
// Valid/ready channel interfaces for received bytes and frame results.
interface sfsc_req_if;
   import sfsc_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfsc_rsp_if;
   import sfsc_pkg::*;

   logic       valid;
   logic       ready;
   logic       crc_ok;
   byte_type   frame_type;
   length_type frame_length;
   byte_type   computed_crc;
   byte_type   received_crc;

   modport source (output valid, output crc_ok, output frame_type, output frame_length,
                   output computed_crc, output received_crc, input ready);
   modport sink   (input valid, input crc_ok, input frame_type, input frame_length,
                   input computed_crc, input received_crc, output ready);
endinterface

// ===== rtl/serial_frame_sync_crc_receiver.sv =====
// Top level of the serial frame receiver with sync hunt and CRC-8 check.
// Bytes enter on the req channel, one beat per byte, and one beat per completed
// frame leaves on the rsp channel. The block takes one byte every clock cycle
// while the result side keeps up. A byte waits in the input register until the
// result register is free or being drained, and is then processed on the edge
// that also loads its result, if any, into the result register. The rate is
// set by the combinational CRC-8 byte step between those two registers. While a
// result waits to be taken, the input register still accepts one more byte.
// Frames start at a byte equal to the sync register; lengths outside
// MIN_FRAME_BYTES..MAX_FRAME_BYTES are dropped silently. Configuration writes
// belong to idle periods and act on the next byte.
module serial_frame_sync_crc_receiver #(
   parameter int unsigned MAX_FRAME_BYTES = sfsc_pkg::MAX_FRAME_BYTES_DEFAULT,
   parameter int unsigned MIN_FRAME_BYTES = sfsc_pkg::MIN_FRAME_BYTES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   sfsc_req_if.sink                req_bus,
   sfsc_rsp_if.source              rsp_bus,
   input  logic                    csr_write_enable,
   input  sfsc_pkg::csr_index_type csr_index,
   input  sfsc_pkg::csr_data_type  csr_write_data
);
   import sfsc_pkg::*;

`include "serial_frame_sync_crc_receiver_defines.svh"

   cfg_type    cfg_ff, cfg_in;
   logic       in_valid_ff, in_valid_in;
   byte_type   in_byte_ff, in_byte_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   logic       advance;
   logic       frame_done;
   result_type frame_result;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SYNC_VALUE:     cfg_in.sync_value     = csr_write_data;
            CSR_CRC_POLYNOMIAL: cfg_in.crc_polynomial = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_value     <= SYNC_VALUE_RESET;
         cfg_ff.crc_polynomial <= CRC_POLYNOMIAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The held byte moves on when the result register is free or being drained.
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
         in_byte_in  = req_bus.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
   end

   sfsc_framer #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
      .MIN_FRAME_BYTES (MIN_FRAME_BYTES)
   ) u_framer (
      .clock        (clock),
      .reset        (reset),
      .byte_strobe  (advance),
      .rx_byte      (in_byte_ff),
      .cfg          (cfg_ff),
      .result_valid (frame_done),
      .result       (frame_result)
   );

   // Result register.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance && frame_done) begin
         out_valid_in = 1'b1;
         out_in       = frame_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.crc_ok       = out_ff.crc_ok;
   assign rsp_bus.frame_type   = out_ff.frame_type;
   assign rsp_bus.frame_length = out_ff.frame_length;
   assign rsp_bus.computed_crc = out_ff.computed_crc;
   assign rsp_bus.received_crc = out_ff.received_crc;

   // A reported frame length always passed the length check.
   `SFSC_ASSERT_NOW(a_length_in_range, rsp_bus.valid,
      (rsp_bus.frame_length <= LENGTH_WIDTH'(MAX_FRAME_BYTES)) &&
      (rsp_bus.frame_length >= LENGTH_WIDTH'(MIN_FRAME_BYTES)),
      "frame length outside the accepted range")
   // The check flag agrees with the two CRC values it reports.
   `SFSC_ASSERT_NOW(a_crc_flag, rsp_bus.valid,
      rsp_bus.crc_ok == (rsp_bus.computed_crc == rsp_bus.received_crc),
      "crc_ok disagrees with the reported CRC values")
   // A byte held behind a stalled result stays put until it can be processed.
   `SFSC_ASSERT_NEXT(a_input_held, in_valid_ff && out_valid_ff && !rsp_bus.ready,
      in_valid_ff && $stable(in_byte_ff),
      "input byte lost while the result register was stalled")

endmodule

// ===== rtl/sfsc_framer.sv =====
// Frame tracking state machine: sync hunt, length check and running CRC-8.
module sfsc_framer #(
   parameter int unsigned MAX_FRAME_BYTES = sfsc_pkg::MAX_FRAME_BYTES_DEFAULT,
   parameter int unsigned MIN_FRAME_BYTES = sfsc_pkg::MIN_FRAME_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_strobe,
   input  sfsc_pkg::byte_type   rx_byte,
   input  sfsc_pkg::cfg_type    cfg,
   output logic                 result_valid,
   output sfsc_pkg::result_type result
);
   import sfsc_pkg::*;

   frame_state_type state_ff, state_in;
   length_type      count_ff, count_in;
   length_type      expected_ff, expected_in;
   byte_type        crc_ff, crc_in;
   byte_type        type_ff, type_in;

   logic [BYTE_WIDTH:0]   total_len;
   logic [LENGTH_WIDTH:0] next_count;
   logic                  len_bad;

   // Length field plus overhead, and the position after the current byte.
   assign total_len  = {1'b0, rx_byte} + (BYTE_WIDTH+1)'(LENGTH_OVERHEAD);
   assign len_bad    = (total_len > (BYTE_WIDTH+1)'(MAX_FRAME_BYTES)) ||
                       (total_len < (BYTE_WIDTH+1)'(MIN_FRAME_BYTES));
   assign next_count = {1'b0, count_ff} + (LENGTH_WIDTH+1)'(1);

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_HUNT;
         count_ff    <= '0;
         expected_ff <= '0;
         crc_ff      <= '0;
         type_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         expected_ff <= expected_in;
         crc_ff      <= crc_in;
         type_ff     <= type_in;
      end
   end

   // Next state and result for one byte.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      expected_in  = expected_ff;
      crc_in       = crc_ff;
      type_in      = type_ff;
      result_valid = 1'b0;
      result.crc_ok       = (crc_ff == rx_byte);
      result.frame_type   = type_ff;
      result.frame_length = expected_ff;
      result.computed_crc = crc_ff;
      result.received_crc = rx_byte;

      if (byte_strobe) begin
         case (state_ff)
            ST_HUNT: begin
               if (rx_byte == cfg.sync_value) begin
                  state_in    = ST_LENGTH;
                  crc_in      = '0;
                  type_in     = '0;
                  expected_in = '0;
               end
            end
            ST_LENGTH: begin
               // An out-of-range length drops the frame without a result.
               if (len_bad) begin
                  state_in = ST_HUNT;
               end else begin
                  state_in    = ST_BODY;
                  expected_in = total_len[LENGTH_WIDTH-1:0];
                  count_in    = LENGTH_WIDTH'(TYPE_BYTE_INDEX);
               end
            end
            ST_BODY: begin
               if (next_count >= {1'b0, expected_ff}) begin
                  // Final byte carries the CRC.
                  result_valid = 1'b1;
                  state_in     = ST_HUNT;
               end else begin
                  if (count_ff == LENGTH_WIDTH'(TYPE_BYTE_INDEX)) begin
                     type_in = rx_byte;
                  end
                  crc_in   = crc8_step(crc_ff, rx_byte, cfg.crc_polynomial);
                  count_in = next_count[LENGTH_WIDTH-1:0];
               end
            end
            default: begin
               state_in = ST_HUNT;
            end
         endcase
      end
   end

endmodule

// ===== tb/serial_frame_sync_crc_receiver_checker.sv =====
// Frame result checker: tracks the framer from the byte and register traffic and compares results.
package sfsc_tb_pkg;
   import sfsc_pkg::*;

   // Advance a CRC-8 (MSB first) by one byte, shifting one bit at a time.
   function automatic byte_type crc8_next(byte_type acc, byte_type data, byte_type poly);
      byte_type r;
      logic     msb;
      r = acc ^ data;
      repeat (8) begin
         msb = r[7];
         r = r << 1;
         if (msb) begin
            r = r ^ poly;
         end
      end
      return r;
   endfunction
endpackage

module serial_frame_sync_crc_receiver_checker #(
   parameter int unsigned MAX_FRAME_BYTES = sfsc_pkg::MAX_FRAME_BYTES_DEFAULT,
   parameter int unsigned MIN_FRAME_BYTES = sfsc_pkg::MIN_FRAME_BYTES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   sfsc_req_if                     req_mon,
   sfsc_rsp_if                     rsp_mon,
   input  logic                    csr_write_enable,
   input  sfsc_pkg::csr_index_type csr_index,
   input  sfsc_pkg::csr_data_type  csr_write_data,
   output int                      frames_pending,
   output int                      mismatches
);
   timeunit 1ns;
   timeprecision 1ps;
   import sfsc_pkg::*;
   import sfsc_tb_pkg::*;

   frame_state_type framer_state;
   length_type      bytes_seen;
   length_type      frame_total;
   byte_type        crc_running;
   byte_type        type_seen;
   byte_type        sync_reg;
   byte_type        poly_reg;
   result_type      frame_results_due[$];
   int              error_count;

   // Follow one received byte through the framer; a finished frame queues its result.
   task automatic advance_framer(input byte_type b);
      int unsigned total;
      result_type  done;
      case (framer_state)
         ST_HUNT: begin
            if (b == sync_reg) begin
               framer_state = ST_LENGTH;
               bytes_seen   = 1;
               crc_running  = '0;
               type_seen    = '0;
               frame_total  = '0;
            end
         end
         ST_LENGTH: begin
            // Out-of-range lengths drop the frame and go back to hunting.
            total = b + LENGTH_OVERHEAD;
            if (total > MAX_FRAME_BYTES || total < MIN_FRAME_BYTES) begin
               framer_state = ST_HUNT;
               bytes_seen   = 0;
            end else begin
               frame_total  = length_type'(total);
               bytes_seen   = 2;
               framer_state = ST_BODY;
            end
         end
         default: begin
            if (int'(bytes_seen) + 1 >= int'(frame_total)) begin
               // This is the CRC byte.
               done.crc_ok       = (crc_running == b);
               done.frame_type   = type_seen;
               done.frame_length = frame_total;
               done.computed_crc = crc_running;
               done.received_crc = b;
               frame_results_due.push_back(done);
               framer_state = ST_HUNT;
               bytes_seen   = 0;
            end else begin
               if (bytes_seen == TYPE_BYTE_INDEX) begin
                  type_seen = b;
               end
               crc_running = crc8_next(crc_running, b, poly_reg);
               bytes_seen  = bytes_seen + 1;
            end
         end
      endcase
   endtask

   task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Compare one result beat with the oldest outstanding frame.
   task automatic check_result();
      result_type seen;
      result_type want;
      seen = {rsp_mon.crc_ok, rsp_mon.frame_type, rsp_mon.frame_length,
              rsp_mon.computed_crc, rsp_mon.received_crc};
      if (frame_results_due.size() == 0) begin
         $display("%0t ns: unexpected result beat, expected none, actual %h", $time, seen);
         error_count++;
      end else begin
         want = frame_results_due.pop_front();
         compare_field("crc_ok", want.crc_ok, seen.crc_ok);
         compare_field("frame_type", want.frame_type, seen.frame_type);
         compare_field("frame_length", want.frame_length, seen.frame_length);
         compare_field("computed_crc", want.computed_crc, seen.computed_crc);
         compare_field("received_crc", want.received_crc, seen.received_crc);
      end
   endtask

   // Sample register writes and both channels at every rising edge.
   always @(posedge clock) begin
      if (reset) begin
         framer_state = ST_HUNT;
         bytes_seen   = '0;
         frame_total  = '0;
         crc_running  = '0;
         type_seen    = '0;
         sync_reg     = SYNC_VALUE_RESET;
         poly_reg     = CRC_POLYNOMIAL_RESET;
         frame_results_due.delete();
         error_count  = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SYNC_VALUE:     sync_reg = csr_write_data;
               CSR_CRC_POLYNOMIAL: poly_reg = csr_write_data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            advance_framer(req_mon.rx_byte);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_result();
         end
      end
      frames_pending <= frame_results_due.size();
      mismatches     <= error_count;
   end

endmodule

// ===== tb/serial_frame_sync_crc_receiver_tb.sv =====
// Testbench top: clock, reset, byte and register stimulus, result back-pressure and verdict.
module serial_frame_sync_crc_receiver_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sfsc_pkg::*;
   import sfsc_tb_pkg::*;

   // Index past the end of the register list; writes to it must be ignored.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int HOLD_OFF_CYCLES = 300;

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_write_enable;
   csr_index_type csr_index;
   csr_data_type  csr_write_data;
   int            frames_pending;
   int            mismatches;

   byte_type      cur_sync;
   byte_type      cur_poly;
   byte_type      frame_body[$];
   int            bytes_sent = 0;
   int            req_idle_pct = 28;
   int            rsp_idle_pct = 74;
   int            hold_requests = 0;
   int            hold_served = 0;
   int            hold_left = 0;

   sfsc_req_if req_bus();
   sfsc_rsp_if rsp_bus();

   serial_frame_sync_crc_receiver u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   serial_frame_sync_crc_receiver_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .frames_pending   (frames_pending),
      .mismatches       (mismatches)
   );

   always #6 clock = ~clock;

   // Offer one byte after a random idle gap and hold it until the beat is taken.
   task automatic send_byte(input byte_type value);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < req_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= value;
      do @(posedge clock); while (!req_bus.ready);
      bytes_sent++;
   endtask

   // Sync and length field only; used alone for dropped lengths and cut frames, and to start every whole frame.
   task automatic send_header(input byte_type length_field);
      send_byte(cur_sync);
      send_byte(length_field);
   endtask

   // Whole frame around frame_body, with a correct or a deliberately corrupted CRC byte.
   task automatic send_frame(input bit crc_good);
      byte_type crc;
      crc = 8'h00;
      send_header(byte_type'(frame_body.size() + 1));
      foreach (frame_body[i]) begin
         crc = crc8_next(crc, frame_body[i], cur_poly);
         send_byte(frame_body[i]);
      end
      if (!crc_good) begin
         crc ^= byte_type'(1 << $urandom_range(7));
      end
      send_byte(crc);
   endtask

   task automatic load_random_body(input int body_len);
      frame_body.delete();
      repeat (body_len) frame_body.push_back(byte_type'($urandom_range(255)));
   endtask

   // Mostly well-formed frames of random content, with noise, bad lengths and cut frames.
   task automatic random_traffic(input int until_bytes);
      int pick;
      int body_len;
      while (bytes_sent < until_bytes) begin
         repeat ($urandom_range(2)) send_byte(byte_type'($urandom_range(255)));
         pick = $urandom_range(99);
         if (pick < 6) begin
            send_header($urandom_range(1) ? byte_type'($urandom_range(1))
                                          : byte_type'($urandom_range(255, 63)));
         end else if (pick < 10) begin
            // Frame cut short; whatever follows is taken as its body.
            send_header(byte_type'($urandom_range(10, 2)));
            repeat ($urandom_range(2)) send_byte(byte_type'($urandom_range(255)));
         end else begin
            if (pick < 70) begin
               body_len = $urandom_range(7, 1);
            end else if (pick < 88) begin
               body_len = $urandom_range(30, 8);
            end else if (pick < 96) begin
               body_len = $urandom_range(61, 31);
            end else begin
               body_len = 61;
            end
            load_random_body(body_len);
            send_frame($urandom_range(99) < 80);
         end
      end
   endtask

   // Stop sending, let every result drain and give the block time to finish.
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (frames_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_regs(input byte_type sync_val, input byte_type poly_val,
                               input bit poke_unused);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SYNC_VALUE;
      csr_write_data   <= sync_val;
      @(posedge clock);
      csr_index        <= CSR_CRC_POLYNOMIAL;
      csr_write_data   <= poly_val;
      @(posedge clock);
      if (poke_unused) begin
         csr_index      <= csr_index_type'(CSR_UNUSED_INDEX);
         csr_write_data <= csr_data_type'($urandom_range(255));
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      cur_sync = sync_val;
      cur_poly = poly_val;
   endtask

   // Result side: random stalls, plus a long hold-off whenever one is requested.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_OFF_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Main stimulus sequence.
   initial begin
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.rx_byte  <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_SYNC_VALUE;
      csr_write_data   <= '0;
      cur_sync = SYNC_VALUE_RESET;
      cur_poly = CRC_POLYNOMIAL_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed bytes with the reset register values.
      send_byte(8'h00);
      send_byte(8'hFF);
      frame_body = '{8'hFF};
      send_frame(1'b1);
      frame_body = '{8'h00};
      send_frame(1'b0);
      // A sync byte inside a frame is plain data.
      frame_body = '{cur_sync, 8'h00};
      send_frame(1'b1);
      // Too short, too long, and a length byte equal to the sync value.
      send_header(8'd0);
      send_header(8'd1);
      send_header(8'd63);
      send_header(cur_sync);
      frame_body = '{8'h5A, 8'hA5, 8'h3C};
      send_frame(1'b1);
      random_traffic(200);

      settle();
      program_regs(8'h00, 8'h00, 1'b1);
      random_traffic(350);

      // Sender idles more than the receiver from here.
      settle();
      req_idle_pct = 74;
      rsp_idle_pct <= 28;
      program_regs(8'hFF, 8'hFF, 1'b0);
      random_traffic(520);

      settle();
      program_regs(byte_type'($urandom_range(255)), 8'h07, 1'b0);
      random_traffic(690);

      // No idling; the receiver holds off while short frames keep coming.
      settle();
      req_idle_pct = 0;
      rsp_idle_pct <= 0;
      program_regs(byte_type'($urandom_range(255)), byte_type'($urandom_range(255)), 1'b0);
      hold_requests <= hold_requests + 1;
      repeat (12) begin
         load_random_body($urandom_range(3, 1));
         send_frame(1'b1);
      end
      random_traffic(860);

      settle();
      program_regs(SYNC_VALUE_RESET, CRC_POLYNOMIAL_RESET, 1'b0);
      random_traffic(1030);

      settle();
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
